FILE: design/pat_pkg.sv
package pat_pkg;

    localparam int TABLE_SIZE_DEF = 256;

    localparam int ADDR_W  = 32;
    localparam int PKT_W   = 32;
    localparam int BYTE_W  = 48;
    localparam int LEN_W   = 16;
    localparam int SLOT_W  = 8;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 3;

    localparam logic [PKT_W-1:0]  PKT_MAX  = {PKT_W{1'b1}};
    localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

    // request opcodes (code 3 behaves as a read)
    localparam logic [OP_W-1:0] OP_COUNT = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_HIT        = 3'd0;
    localparam logic [STAT_W-1:0] ST_NEW        = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 3'd2;
    localparam logic [STAT_W-1:0] ST_READ_VALID = 3'd3;
    localparam logic [STAT_W-1:0] ST_READ_EMPTY = 3'd4;
    localparam logic [STAT_W-1:0] ST_CLEARED    = 3'd5;

    // table memory strobes
    typedef struct packed {
        logic rd_en;
        logic addr_we;
        logic cnt_we;
    } mem_ctl_t;

endpackage

FILE: design/pat_table.sv
module pat_table
    import pat_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                          clk,
    input  mem_ctl_t                      ctl,
    input  logic [$clog2(TABLE_SIZE)-1:0] rd_idx,
    input  logic [$clog2(TABLE_SIZE)-1:0] wr_idx,
    input  logic [ADDR_W-1:0]             wr_address,
    input  logic [PKT_W-1:0]              wr_packets,
    input  logic [BYTE_W-1:0]             wr_bytes,
    output logic [ADDR_W-1:0]             rd_address,
    output logic [PKT_W-1:0]              rd_packets,
    output logic [BYTE_W-1:0]             rd_bytes
);

    logic [ADDR_W-1:0]       addr_mem [TABLE_SIZE];
    logic [PKT_W+BYTE_W-1:0] cnt_mem  [TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (ctl.addr_we)
        begin
            addr_mem[wr_idx] <= wr_address;
        end
        if (ctl.rd_en)
        begin
            rd_address <= addr_mem[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.cnt_we)
        begin
            cnt_mem[wr_idx] <= {wr_packets, wr_bytes};
        end
        if (ctl.rd_en)
        begin
            {rd_packets, rd_bytes} <= cnt_mem[rd_idx];
        end
    end

endmodule

FILE: design/pat_ctrl.sv
module pat_ctrl
    import pat_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [OP_W-1:0]       opcode,
    input  logic [ADDR_W-1:0]     key,
    input  logic [LEN_W-1:0]      packet_length,
    input  logic [SLOT_W-1:0]     slot_index,
    output logic                  busy,
    output logic                  done,
    output logic [STAT_W-1:0]     status,
    output logic [ADDR_W-1:0]     entry_address,
    output logic [PKT_W-1:0]      entry_packets,
    output logic [BYTE_W-1:0]     entry_bytes,
    output logic [SLOT_W-1:0]     entry_slot
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_INSERT,
        S_RDWAIT
    } state_t;

    state_t              state_reg;
    logic [CNT_W-1:0]    used_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [ADDR_W-1:0]   key_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [SLOT_W-1:0]   idx_reg;

    logic                done_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [ADDR_W-1:0]   address_reg;
    logic [PKT_W-1:0]    packets_reg;
    logic [BYTE_W-1:0]   bytes_reg;
    logic [SLOT_W-1:0]   slot_reg;

    mem_ctl_t            ctl;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    wr_idx;
    logic [PKT_W-1:0]    wr_packets;
    logic [BYTE_W-1:0]   wr_bytes;
    logic [ADDR_W-1:0]   rd_address;
    logic [PKT_W-1:0]    rd_packets;
    logic [BYTE_W-1:0]   rd_bytes;

    logic                accept;
    logic                match;
    logic                room;
    logic                read_ok;
    logic [CNT_W-1:0]    scan_inc;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    used_ext;
    logic [CMP_W-1:0]    scan_ext;
    logic [PKT_W-1:0]    pk_sat;
    logic [BYTE_W:0]     by_sum;
    logic [BYTE_W-1:0]   by_sat;

    assign accept   = start && (state_reg == S_IDLE);
    assign match    = (rd_address == key_reg);
    assign room     = (used_reg < CNT_W'(TABLE_SIZE));
    assign scan_inc = scan_reg + CNT_W'(1);
    assign idx_ext  = CMP_W'(slot_index);
    assign used_ext = CMP_W'(used_reg);
    assign scan_ext = CMP_W'(scan_reg);
    // slots below the fill count are the used ones
    assign read_ok  = (idx_ext < used_ext);

    // saturating counter update on the entry just read
    assign pk_sat = (rd_packets == PKT_MAX) ? rd_packets : rd_packets + PKT_W'(1);
    assign by_sum = {1'b0, rd_bytes} + (BYTE_W + 1)'(len_reg);
    assign by_sat = by_sum[BYTE_W] ? BYTE_MAX : by_sum[BYTE_W-1:0];

    always_comb
    begin
        ctl        = '0;
        rd_idx     = '0;
        wr_idx     = used_reg[IDX_W-1:0];
        wr_packets = PKT_W'(1);
        wr_bytes   = BYTE_W'(len_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && opcode == OP_COUNT)
                begin
                    ctl.rd_en = 1'b1;
                end
                else if (accept && opcode != OP_CLEAR && read_ok)
                begin
                    ctl.rd_en = 1'b1;
                    rd_idx    = idx_ext[IDX_W-1:0];
                end
            end
            S_SCAN:
            begin
                // hold read data on a hit so the update sees it
                ctl.rd_en = !match;
                rd_idx    = scan_inc[IDX_W-1:0];
            end
            S_UPDATE:
            begin
                ctl.cnt_we = 1'b1;
                wr_idx     = scan_reg[IDX_W-1:0];
                wr_packets = pk_sat;
                wr_bytes   = by_sat;
            end
            S_INSERT:
            begin
                ctl.addr_we = room;
                ctl.cnt_we  = room;
            end
            S_RDWAIT:
            begin
                ctl = '0;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    pat_table #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_table (
        .clk        (clk),
        .ctl        (ctl),
        .rd_idx     (rd_idx),
        .wr_idx     (wr_idx),
        .wr_address (key_reg),
        .wr_packets (wr_packets),
        .wr_bytes   (wr_bytes),
        .rd_address (rd_address),
        .rd_packets (rd_packets),
        .rd_bytes   (rd_bytes)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            scan_reg    <= '0;
            key_reg     <= '0;
            len_reg     <= '0;
            idx_reg     <= '0;
            done_reg    <= 1'b0;
            status_reg  <= '0;
            address_reg <= '0;
            packets_reg <= '0;
            bytes_reg   <= '0;
            slot_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        key_reg  <= key;
                        len_reg  <= packet_length;
                        idx_reg  <= slot_index;
                        scan_reg <= '0;
                        unique case (opcode)
                            OP_COUNT:
                            begin
                                state_reg <= (used_reg == '0) ? S_INSERT : S_SCAN;
                            end
                            OP_CLEAR:
                            begin
                                used_reg    <= '0;
                                done_reg    <= 1'b1;
                                status_reg  <= ST_CLEARED;
                                address_reg <= '0;
                                packets_reg <= '0;
                                bytes_reg   <= '0;
                                slot_reg    <= '0;
                            end
                            default:
                            begin
                                if (read_ok)
                                begin
                                    state_reg <= S_RDWAIT;
                                end
                                else
                                begin
                                    done_reg    <= 1'b1;
                                    status_reg  <= ST_READ_EMPTY;
                                    address_reg <= '0;
                                    packets_reg <= '0;
                                    bytes_reg   <= '0;
                                    slot_reg    <= slot_index;
                                end
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (match)
                    begin
                        state_reg <= S_UPDATE;
                    end
                    else if (scan_inc == used_reg)
                    begin
                        state_reg <= S_INSERT;
                    end
                    else
                    begin
                        scan_reg <= scan_inc;
                    end
                end
                S_UPDATE:
                begin
                    state_reg   <= S_IDLE;
                    done_reg    <= 1'b1;
                    status_reg  <= ST_HIT;
                    address_reg <= key_reg;
                    packets_reg <= pk_sat;
                    bytes_reg   <= by_sat;
                    slot_reg    <= scan_ext[SLOT_W-1:0];
                end
                S_INSERT:
                begin
                    state_reg   <= S_IDLE;
                    done_reg    <= 1'b1;
                    address_reg <= key_reg;
                    if (room)
                    begin
                        used_reg    <= used_reg + CNT_W'(1);
                        status_reg  <= ST_NEW;
                        packets_reg <= PKT_W'(1);
                        bytes_reg   <= BYTE_W'(len_reg);
                        slot_reg    <= used_ext[SLOT_W-1:0];
                    end
                    else
                    begin
                        status_reg  <= ST_FULL;
                        packets_reg <= '0;
                        bytes_reg   <= '0;
                        slot_reg    <= '0;
                    end
                end
                S_RDWAIT:
                begin
                    state_reg   <= S_IDLE;
                    done_reg    <= 1'b1;
                    status_reg  <= ST_READ_VALID;
                    address_reg <= rd_address;
                    packets_reg <= rd_packets;
                    bytes_reg   <= rd_bytes;
                    slot_reg    <= idx_reg;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign entry_address = address_reg;
    assign entry_packets = packets_reg;
    assign entry_bytes   = bytes_reg;
    assign entry_slot    = slot_reg;

endmodule

FILE: design/per_address_traffic_counter.sv
// Per-address traffic counter: a table of IPv4 addresses with packet and
// byte counts, filled in order of first appearance.
// Request channel: start/busy; a request is taken at a clock edge with start
// high and busy low. opcode selects count, read slot or clear.
// Result channel: done is high for one cycle with status and entry fields;
// the receiver cannot stall it, and a new request may be taken in the cycle
// a result is shown.
// Config: cfg_we/cfg_wdata write track_source (1 = source, 0 = destination);
// write only while idle.
// Request flow: a clear, or a read of a free slot, is answered from idle; a
// read of a used slot waits in S_RDWAIT for the table read; a count walks
// the used slots, then updates a hit in S_UPDATE or, on a miss or an empty
// table, inserts in S_INSERT, or reports table full when no slot is free.
// The lookup walks the used slots through the single read port of the
// address memory, one slot per cycle.
// Reset: table empty (fill count zero), track_source = 1; no clearing pass
// is needed since data from slots at or above the fill count is never used.
module per_address_traffic_counter
    import pat_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    opcode,
    input  logic [ADDR_W-1:0]  source_address,
    input  logic [ADDR_W-1:0]  destination_address,
    input  logic [LEN_W-1:0]   packet_length,
    input  logic [SLOT_W-1:0]  slot_index,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    output logic               done,
    output logic [STAT_W-1:0]  status,
    output logic [ADDR_W-1:0]  entry_address,
    output logic [PKT_W-1:0]   entry_packets,
    output logic [BYTE_W-1:0]  entry_bytes,
    output logic [SLOT_W-1:0]  entry_slot
);

    // tracked-address select register
    logic              track_source_reg;
    logic              track_source_next;
    logic [ADDR_W-1:0] key;

    assign track_source_next = cfg_we ? cfg_wdata : track_source_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            track_source_reg <= 1'b1;
        end
        else
        begin
            track_source_reg <= track_source_next;
        end
    end

    // lookup key for count requests
    assign key = track_source_reg ? source_address : destination_address;

    pat_ctrl #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .opcode        (opcode),
        .key           (key),
        .packet_length (packet_length),
        .slot_index    (slot_index),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .entry_address (entry_address),
        .entry_packets (entry_packets),
        .entry_bytes   (entry_bytes),
        .entry_slot    (entry_slot)
    );

endmodule
